/* rtl/stftdb_pkg.sv */
// Shared constants, command/status types and ROM builders for the spectrum analyzer.
`timescale 1ns / 1ps
package stftdb_pkg;

  localparam int FFT_SIZE     = 128;
  localparam int AW           = $clog2(FFT_SIZE);
  localparam int SAMPLE_BITS  = 16;
  localparam int D_W          = 24;
  localparam int TW_W         = 24;
  localparam int WIN_W        = 23;
  localparam int ACC_W        = 54;
  localparam int P_W          = 48;
  localparam int CNT_W        = 8;
  localparam int BIN_W        = 6;
  localparam int LEVEL_W      = 16;
  localparam int MIN_DB_W     = 9;
  localparam int MAX_DB_W     = 8;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int SQR_STEPS    = 16;
  localparam int DIV_STEPS    = 16;
  localparam int HOP_SIZE_DEF = 64;
  localparam int NUM_BINS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DB = 1'd1;

  localparam logic signed [MIN_DB_W-1:0] MIN_DB_RST = -9'sd90;
  localparam logic signed [MAX_DB_W-1:0] MAX_DB_RST = 8'sd0;

  localparam logic [29:0] DB_PER_OCT_Q28 = 30'd808071242;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [63:0] Q30_ONE        = 64'd1 << 30;
  localparam longint     Q22_ONE        = 64'sd1 << 22;
  localparam int         D_MAX          = (1 << (D_W - 1)) - 1;
  localparam int         D_MIN          = -(1 << (D_W - 1));

  typedef struct packed {
    logic            ring_we;
    logic            ring_clr;
    logic [AW-1:0]   ring_waddr;
    logic [AW-1:0]   ring_raddr;
    logic            win_issue;
    logic [AW-1:0]   win_idx;
    logic            mac_clear;
    logic            mac_issue;
    logic [AW-1:0]   work_raddr;
    logic [AW-1:0]   tw_idx;
    logic            round_acc;
    logic            square;
    logic            sum;
    logic            norm_step;
    logic            sqr_load;
    logic            sqr_step;
    logic            db_mul;
    logic            db_round;
    logic            scale;
    logic            div_step;
    logic [3:0]      div_bit;
    logic            lvl_zero;
    logic            out_load;
    logic [BIN_W-1:0] out_bin;
    logic            out_last;
  } cmd_t;

  typedef struct packed {
    logic nrm_zero;
    logic nrm_top;
    logic degenerate;
  } status_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } trig_t;

  // Shift-subtract quotient, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Round to nearest, halves away from zero, by 2^sh.
  function automatic longint rnd_sh(input longint a, input int sh);
    longint h;
    h = longint'(1) <<< (sh - 1);
    if (a < 0) return -((-a + h) >>> sh);
    return (a + h) >>> sh;
  endfunction

  function automatic trig_t trig_q30(input logic [31:0] num, input logic [31:0] den);
    logic [63:0] nm, ph, r, th, t2, tc, ts;
    logic signed [63:0] cv, sv;
    logic [1:0] quad;
    trig_t res;
    nm   = (num >= den) ? 64'(num - den) : 64'(num);
    ph   = udiv64(nm << 32, 64'(den));
    quad = ph[31:30];
    r    = ph & 64'h3FFF_FFFF;
    th   = (r * HALF_PI_Q30) >> 30;
    t2   = (th * th) >> 30;
    tc   = Q30_ONE;
    ts   = th;
    cv   = $signed(tc);
    sv   = $signed(ts);
    for (int k = 1; k <= 8; k++) begin
      tc = udiv64((tc * t2) >> 30, 64'((2 * k - 1) * (2 * k)));
      ts = udiv64((ts * t2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if (k % 2 == 1) begin
        cv = cv - $signed(tc);
        sv = sv - $signed(ts);
      end else begin
        cv = cv + $signed(tc);
        sv = sv + $signed(ts);
      end
    end
    case (quad)
      2'd0: begin res.c = cv;  res.s = sv;  end
      2'd1: begin res.c = -sv; res.s = cv;  end
      2'd2: begin res.c = -cv; res.s = -sv; end
      default: begin res.c = sv; res.s = -cv; end
    endcase
    return res;
  endfunction

  function automatic logic signed [TW_W-1:0] cos_q22(input int i);
    trig_t t;
    t = trig_q30(32'(i), 32'(FFT_SIZE));
    return TW_W'(rnd_sh(t.c, 8));
  endfunction

  function automatic logic signed [TW_W-1:0] sin_q22(input int i);
    trig_t t;
    t = trig_q30(32'(i), 32'(FFT_SIZE));
    return TW_W'(rnd_sh(t.s, 8));
  endfunction

  function automatic logic [WIN_W-1:0] win_q22(input int i);
    trig_t t;
    longint w;
    t = trig_q30(32'(i), 32'(FFT_SIZE - 1));
    w = rnd_sh(longint'(Q30_ONE) - t.c, 9);
    if (w < 0) w = 0;
    if (w > Q22_ONE) w = Q22_ONE;
    return WIN_W'(w);
  endfunction

  // Saturate to the 24-bit internal format.
  function automatic logic signed [D_W-1:0] sat_d(input logic signed [31:0] v);
    if (v > 32'(D_MAX)) return D_W'(D_MAX);
    if (v < 32'(D_MIN)) return D_W'(D_MIN);
    return v[D_W-1:0];
  endfunction

endpackage

/* rtl/stftdb_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module stftdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/stftdb_ctrl.sv */
// Sequencer for sample capture, windowing, per-bin DFT and level conversion.
`timescale 1ns / 1ps
module stftdb_ctrl #(
  parameter int HOP_SIZE = stftdb_pkg::HOP_SIZE_DEF,
  parameter int NUM_BINS = stftdb_pkg::NUM_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  stftdb_pkg::status_t st,
  output stftdb_pkg::cmd_t    cmd
);
  import stftdb_pkg::*;

  localparam int HOP_W = (HOP_SIZE > 1) ? $clog2(HOP_SIZE) : 1;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_WIN   = 14'b00000000000100,
    S_MAC   = 14'b00000000001000,
    S_ROUND = 14'b00000000010000,
    S_SQ    = 14'b00000000100000,
    S_SUM   = 14'b00000001000000,
    S_NORM  = 14'b00000010000000,
    S_SQR   = 14'b00000100000000,
    S_DB    = 14'b00001000000000,
    S_RND   = 14'b00010000000000,
    S_SCALE = 14'b00100000000000,
    S_DIV   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [AW-1:0]      m_r, m_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [HOP_W-1:0]   hop_r, hop_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               last_bin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign last_bin  = (bin_r == BIN_W'(NUM_BINS - 1));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    bin_nxt    = bin_r;
    m_nxt      = m_r;
    wp_nxt     = wp_r;
    hop_nxt    = hop_r;
    cmd        = '0;
    cmd.ring_waddr = wp_r;
    cmd.ring_raddr = wp_r + cnt_r[AW-1:0];
    cmd.win_idx    = cnt_r[AW-1:0];
    cmd.work_raddr = cnt_r[AW-1:0];
    cmd.tw_idx     = m_r;
    cmd.div_bit    = cnt_r[3:0];
    cmd.out_bin    = bin_r;
    cmd.out_last   = last_bin;
    unique case (state_r)
      S_CLEAR: begin
        cmd.ring_we    = 1'b1;
        cmd.ring_clr   = 1'b1;
        cmd.ring_waddr = cnt_r[AW-1:0];
        if (cnt_r == CNT_W'(FFT_SIZE - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ring_we = 1'b1;
          wp_nxt      = wp_r + 1'b1;
          if (hop_r == HOP_W'(HOP_SIZE - 1)) begin
            hop_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_WIN;
          end else begin
            hop_nxt = hop_r + 1'b1;
          end
        end
      end
      S_WIN: begin
        cmd.win_issue = (cnt_r < CNT_W'(FFT_SIZE));
        if (cnt_r == CNT_W'(FFT_SIZE)) begin
          state_nxt = S_MAC;
          cnt_nxt   = '0;
          bin_nxt   = '0;
          m_nxt     = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MAC: begin
        cmd.mac_clear = (cnt_r == '0);
        cmd.mac_issue = (cnt_r < CNT_W'(FFT_SIZE));
        m_nxt         = m_r + AW'(bin_r);
        if (cnt_r == CNT_W'(FFT_SIZE + 1)) begin
          state_nxt = S_ROUND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round_acc = 1'b1;
        state_nxt     = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (st.nrm_zero) begin
          cmd.lvl_zero = 1'b1;
          state_nxt    = S_OUT;
        end else if (st.nrm_top) begin
          cmd.sqr_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_SQR;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQR: begin
        cmd.sqr_step = 1'b1;
        if (cnt_r == CNT_W'(SQR_STEPS - 1)) begin
          state_nxt = S_DB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DB: begin
        cmd.db_mul = 1'b1;
        state_nxt  = S_RND;
      end
      S_RND: begin
        cmd.db_round = 1'b1;
        state_nxt    = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        if (st.degenerate) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt   = CNT_W'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          cnt_nxt      = '0;
          m_nxt        = '0;
          if (last_bin) begin
            state_nxt = S_IDLE;
          end else begin
            bin_nxt   = bin_r + 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      bin_r       <= '0;
      m_r         <= '0;
      wp_r        <= '0;
      hop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bin_r       <= bin_nxt;
      m_r         <= m_nxt;
      wp_r        <= wp_nxt;
      hop_r       <= hop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/stftdb_dp.sv */
// Datapath: sample ring, window multiply, DFT MAC, power, log2, dB scaling and divider.
`timescale 1ns / 1ps
module stftdb_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [stftdb_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 cfg_we,
  input  logic [stftdb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stftdb_pkg::CFG_W-1:0]         cfg_wdata,
  input  stftdb_pkg::cmd_t                     cmd,
  output stftdb_pkg::status_t                  st,
  output logic [stftdb_pkg::BIN_W-1:0]         out_bin_index,
  output logic [stftdb_pkg::LEVEL_W-1:0]       out_level,
  output logic                                 out_last_bin
);
  import stftdb_pkg::*;

  localparam int WPROD_W = SAMPLE_BITS + WIN_W + 1;
  localparam int PROD_W  = D_W + TW_W;
  localparam int DBP_W   = 23 + 31;
  localparam int DB_W    = 26;
  localparam int CMP_W   = 28;
  localparam int N_W     = 42;
  localparam int REM_W   = 26;

  // Constant tables
  logic signed [TW_W-1:0] cos_tab [FFT_SIZE];
  logic signed [TW_W-1:0] sin_tab [FFT_SIZE];
  logic        [WIN_W-1:0] win_tab [FFT_SIZE];

  for (genvar gi = 0; gi < FFT_SIZE; gi++) begin : g_rom
    localparam logic signed [TW_W-1:0] CV = cos_q22(gi);
    localparam logic signed [TW_W-1:0] SV = sin_q22(gi);
    localparam logic        [WIN_W-1:0] WV = win_q22(gi);
    assign cos_tab[gi] = CV;
    assign sin_tab[gi] = SV;
    assign win_tab[gi] = WV;
  end

  logic signed [MIN_DB_W-1:0] min_db_r;
  logic signed [MAX_DB_W-1:0] max_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_db_r <= MIN_DB_RST;
      max_db_r <= MAX_DB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_DB: min_db_r <= cfg_wdata;
        CFG_MAX_DB: max_db_r <= cfg_wdata[MAX_DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample ring
  logic [SAMPLE_BITS-1:0] ring_rdata;

  stftdb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FFT_SIZE)) u_ring (
    .clk   (clk),
    .we    (cmd.ring_we),
    .waddr (cmd.ring_waddr),
    .wdata (cmd.ring_clr ? '0 : in_sample),
    .raddr (cmd.ring_raddr),
    .rdata (ring_rdata)
  );

  // Windowing
  logic              win_v_r;
  logic [AW-1:0]     win_idx_r;
  logic signed [WPROD_W-1:0] wprod, wsum;
  logic signed [D_W-1:0]     wval;
  logic [D_W-1:0]    work_rdata;

  assign wprod = $signed(ring_rdata) * $signed({1'b0, win_tab[win_idx_r]});
  assign wsum  = wprod + WPROD_W'(1 << 13) - WPROD_W'(wprod < 0);
  assign wval  = sat_d(32'($signed(wsum[WPROD_W-1:14])));

  stftdb_ram #(.WIDTH(D_W), .DEPTH(FFT_SIZE)) u_work (
    .clk   (clk),
    .we    (win_v_r),
    .waddr (win_idx_r),
    .wdata (wval),
    .raddr (cmd.work_raddr),
    .rdata (work_rdata)
  );

  // DFT multiply-accumulate
  logic              mac_v1_r, mac_v2_r;
  logic [AW-1:0]     tw1_r;
  logic signed [PROD_W-1:0] pre_r, pim_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r, asum_re, asum_im;
  logic signed [D_W-1:0]    re_r, im_r;
  logic [P_W-1:0]    sq_re_r, sq_im_r;

  assign asum_re = acc_re_r + ACC_W'(64'd1 << 28) - ACC_W'(acc_re_r < 0);
  assign asum_im = acc_im_r + ACC_W'(64'd1 << 28) - ACC_W'(acc_im_r < 0);

  // Log2 and level conversion
  logic [P_W-1:0]    nrm_r;
  logic [5:0]        e_r;
  logic [31:0]       mnt_r;
  logic [15:0]       frac_r;
  logic [63:0]       msq;
  logic [31:0]       mt;
  logic signed [6:0] e_off;
  logic signed [22:0] l2;
  logic signed [DBP_W-1:0] dbp_r, dsum;
  logic signed [DB_W-1:0]  db_r;
  logic signed [CMP_W-1:0] lo, hi, dbx, dbc, xs;
  logic [9:0]        dd;
  logic [N_W-1:0]    nsum;
  logic [REM_W-1:0]  rem_r, dsh;
  logic [LEVEL_W-1:0] q_r;

  assign msq   = mnt_r * mnt_r;
  assign mt    = msq[61:30];
  assign e_off = $signed(7'(e_r)) - 7'sd46;
  assign l2    = $signed({e_off, frac_r});
  assign dsum  = dbp_r + DBP_W'(64'd1 << 27) - DBP_W'(dbp_r < 0);

  assign lo  = CMP_W'($signed({min_db_r, 16'h0}));
  assign hi  = CMP_W'($signed({max_db_r, 16'h0}));
  assign dbx = CMP_W'(db_r);
  assign dd  = 10'(max_db_r) - 10'(min_db_r);

  always_comb begin
    if (dbx < lo) begin
      dbc = lo;
    end else if (dbx > hi) begin
      dbc = hi;
    end else begin
      dbc = dbx;
    end
  end

  assign xs   = dbc - lo;
  assign nsum = {xs[REM_W-1:0], 16'h0} - N_W'(xs[REM_W-1:0]) + (N_W'(dd) << 15);
  assign dsh  = REM_W'(dd) << cmd.div_bit;

  assign st.nrm_zero   = (nrm_r == '0);
  assign st.nrm_top    = nrm_r[P_W-1];
  assign st.degenerate = ($signed(10'(max_db_r)) <= $signed(10'(min_db_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_v_r  <= 1'b0;
      mac_v1_r <= 1'b0;
      mac_v2_r <= 1'b0;
    end else begin
      win_v_r  <= cmd.win_issue;
      mac_v1_r <= cmd.mac_issue;
      mac_v2_r <= mac_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    win_idx_r <= cmd.win_idx;
    tw1_r     <= cmd.tw_idx;
    if (mac_v1_r) begin
      pre_r <= $signed(work_rdata) * cos_tab[tw1_r];
      pim_r <= $signed(work_rdata) * sin_tab[tw1_r];
    end
    if (cmd.mac_clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (mac_v2_r) begin
      acc_re_r <= acc_re_r + ACC_W'(pre_r);
      acc_im_r <= acc_im_r + ACC_W'(pim_r);
    end
    if (cmd.round_acc) begin
      re_r <= sat_d(32'($signed(asum_re[ACC_W-1:29])));
      im_r <= sat_d(32'($signed(asum_im[ACC_W-1:29])));
    end
    if (cmd.square) begin
      sq_re_r <= $unsigned(P_W'(re_r) * P_W'(re_r));
      sq_im_r <= $unsigned(P_W'(im_r) * P_W'(im_r));
    end
    if (cmd.sum) begin
      nrm_r <= sq_re_r + sq_im_r;
      e_r   <= 6'(P_W - 1);
    end else if (cmd.norm_step) begin
      nrm_r <= {nrm_r[P_W-2:0], 1'b0};
      e_r   <= e_r - 1'b1;
    end
    if (cmd.sqr_load) begin
      mnt_r  <= {1'b0, nrm_r[P_W-1:P_W-31]};
      frac_r <= '0;
    end else if (cmd.sqr_step) begin
      if (mt[31]) begin
        mnt_r  <= {1'b0, mt[31:1]};
        frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        mnt_r  <= mt;
        frac_r <= {frac_r[14:0], 1'b0};
      end
    end
    if (cmd.db_mul) begin
      dbp_r <= l2 * $signed({1'b0, DB_PER_OCT_Q28});
    end
    if (cmd.db_round) begin
      db_r <= dsum[DBP_W-1:28];
    end
    if (cmd.lvl_zero) begin
      q_r <= '0;
    end else if (cmd.scale) begin
      rem_r <= nsum[N_W-1:16];
      if (st.degenerate) begin
        q_r <= (dbx >= hi) ? '1 : '0;
      end else begin
        q_r <= '0;
      end
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
        q_r   <= q_r | (LEVEL_W'(1) << cmd.div_bit);
      end
    end
    if (cmd.out_load) begin
      out_bin_index <= cmd.out_bin;
      out_level     <= q_r;
      out_last_bin  <= cmd.out_last;
    end
  end

endmodule

/* rtl/stft_magnitude_db_analyzer_top.sv */
// Top level of the windowed spectrum analyzer with dB bin levels.
// Flow: a hop-closing sample starts a frame that windows the ring into work RAM;
// each bin then runs a MAC pass, rounding, squaring, sum, normalize shifts (zero
// power skips to output), 16 log2 squarings, dB multiply and round, scaling and 16
// divide steps (none if the dB range is degenerate). Throughput: one sample per cycle
// between frames; the per-bin loop sets the frame time. Reset clears the ring first.
`timescale 1ns / 1ps
module stft_magnitude_db_analyzer_top #(
  parameter int HOP_SIZE = stftdb_pkg::HOP_SIZE_DEF,
  parameter int NUM_BINS = stftdb_pkg::NUM_BINS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [stftdb_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [stftdb_pkg::BIN_W-1:0]              out_bin_index,
  output logic [stftdb_pkg::LEVEL_W-1:0]            out_level,
  output logic                                      out_last_bin,
  input  logic                                      cfg_we,
  input  logic [stftdb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [stftdb_pkg::CFG_W-1:0]              cfg_wdata
);
  import stftdb_pkg::*;

  // Commands flow from the sequencer, status flags back from the datapath.
  cmd_t    cmd;
  status_t st;

  // Sequencer: hop counting, ring addressing, per-bin loop and output handshake.
  stftdb_ctrl #(.HOP_SIZE(HOP_SIZE), .NUM_BINS(NUM_BINS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: memories, arithmetic and the output item register.
  stftdb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sample     (in_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .st            (st),
    .out_bin_index (out_bin_index),
    .out_level     (out_level),
    .out_last_bin  (out_last_bin)
  );

endmodule

/* rtl/stftdb_chk.sv */
// Port-level assertion checker for the spectrum analyzer, bound to the top level.
`timescale 1ns / 1ps
module stftdb_chk #(
  parameter int NUM_BINS = stftdb_pkg::NUM_BINS_DEF
) (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_ready,
  input logic                                      out_valid,
  input logic                                      out_ready,
  input logic [stftdb_pkg::BIN_W-1:0]              out_bin_index,
  input logic [stftdb_pkg::LEVEL_W-1:0]            out_level,
  input logic                                      out_last_bin
);
  import stftdb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_bin_index)
                                && $stable(out_last_bin))
    else $error("stalled output item changed");

  a_clear_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during ring clearing");

  a_last_bin_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> out_bin_index == BIN_W'(NUM_BINS - 1))
    else $error("last bin flag on wrong bin");

  a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_bin |-> !in_ready)
    else $error("input taken while a frame is still running");

endmodule

bind stft_magnitude_db_analyzer_top stftdb_chk #(.NUM_BINS(NUM_BINS)) u_chk (.*);
